FILE: hw/rtl/bpr_pkg.sv
package bpr_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned ADDR_W     = $clog2(MAX_WIDTH);
  localparam int unsigned CNT_W      = 12;
  localparam int unsigned CFG_W      = 13;
  localparam int unsigned VSUM_W     = SAMPLE_W + 2;
  localparam int unsigned HSUM_W     = SAMPLE_W + 4;
  localparam int unsigned OUTQ_DEPTH = 4;
  localparam int unsigned OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int unsigned OUTQ_CNT_W = OUTQ_PTR_W + 1;

  localparam logic [CFG_W-1:0] LINE_WIDTH_RST = CFG_W'(512);
  localparam logic [CFG_W-1:0] WIDTH_MIN      = CFG_W'(2);
  localparam logic [CFG_W-1:0] WIDTH_MAX      = CFG_W'(MAX_WIDTH);

  typedef struct packed {
    logic                       valid;
    logic                       odd_row;
    logic                       odd_col;
    logic                       first_col;
    logic                       second_row;
    logic                       eof;
    logic signed [SAMPLE_W-1:0] sample;
  } tag_t;

  typedef struct packed {
    logic                       last;
    logic signed [SAMPLE_W-1:0] data;
  } result_t;

  function automatic logic [CNT_W-1:0] last_column(input logic [CFG_W-1:0] lw);
    logic [CFG_W-1:0] w;
    w = {lw[CFG_W-1:1], 1'b0};
    if (w < WIDTH_MIN) begin
      w = WIDTH_MIN;
    end
    if (w > WIDTH_MAX) begin
      w = WIDTH_MAX;
    end
    w = w - CFG_W'(1);
    return w[CNT_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/bpr_ram.sv
module bpr_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/bpr_filter.sv
module bpr_filter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bpr_pkg::tag_t                     tag_i,
  input  logic [bpr_pkg::SAMPLE_W-1:0]      even_rd_i,
  input  logic [bpr_pkg::SAMPLE_W-1:0]      odd_rd_i,
  output logic                              push_o,
  output bpr_pkg::result_t                  result_o,
  output logic                              busy_o
);
  import bpr_pkg::*;

  logic signed [VSUM_W-1:0] mid, above, v_d, v_q;
  logic                     valid_q, odd_col_q, first_col_q, eof_q;
  logic signed [VSUM_W-1:0] even_q, even_d, left_q, left_d;
  logic signed [HSUM_W-1:0] hsum;
  logic                     active;

  // vertical sum on the freshly read column
  always_comb begin
    mid   = VSUM_W'($signed(even_rd_i));
    above = tag_i.second_row ? mid : VSUM_W'($signed(odd_rd_i));
    v_d   = above + (mid <<< 1) + VSUM_W'(tag_i.sample);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= tag_i.valid && tag_i.odd_row;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q         <= v_d;
    odd_col_q   <= tag_i.odd_col;
    first_col_q <= tag_i.first_col;
    eof_q       <= tag_i.eof;
  end

  // horizontal sum and rounding
  always_comb begin
    active = valid_q;
    even_d = even_q;
    left_d = left_q;
    hsum   = HSUM_W'(left_q) + (HSUM_W'(even_q) <<< 1) + HSUM_W'(v_q) + HSUM_W'(8);
    if (active) begin
      if (!odd_col_q) begin
        even_d = v_q;
        if (first_col_q) begin
          left_d = v_q;
        end
      end else begin
        left_d = v_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      even_q <= '0;
      left_q <= '0;
    end else begin
      even_q <= even_d;
      left_q <= left_d;
    end
  end

  assign push_o        = active && odd_col_q;
  assign result_o.data = hsum[HSUM_W-1:4];
  assign result_o.last = eof_q;
  assign busy_o        = active && odd_col_q;

endmodule

FILE: hw/rtl/bpr_outq.sv
module bpr_outq (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  bpr_pkg::result_t                result_i,
  input  logic                            pop_i,
  output logic                            valid_o,
  output bpr_pkg::result_t                result_o,
  output logic [bpr_pkg::OUTQ_CNT_W-1:0]  count_o
);
  import bpr_pkg::*;

  result_t                 entry_q [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [OUTQ_CNT_W-1:0]   count_q, count_d;
  logic                    do_pop;

  assign do_pop = pop_i && (count_q != '0);

  always_comb begin
    count_d = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + OUTQ_CNT_W'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - OUTQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + OUTQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + OUTQ_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= result_i;
    end
  end

  assign valid_o  = (count_q != '0);
  assign result_o = entry_q[rd_ptr_q];
  assign count_o  = count_q;

endmodule

FILE: hw/rtl/binomial_pyramid_reduce.sv
// Streaming 2x pyramid reduction with a 3x3 [1 2 1] binomial kernel and (sum+8)>>4
// rounding. One sample is taken per clock unless stalled; the result for output (x, y)
// goes from the odd-row, odd-column sample that completes it through the tag register
// and the filter's vertical-sum register into a four-entry output queue, so input is
// held off only once the results in that queue and in the pipeline fill its four entries.
// Two single-port-write line memories of 4096 x 16 bits hold the last even and odd
// rows; a line memory entry is read and rewritten in the same cycle, read-first. Write
// line_width only while idle; odd values are rounded down and the range is 2 to 4096.
module binomial_pyramid_reduce (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bpr_pkg::CFG_W-1:0]         cfg_line_width_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [bpr_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                              end_of_frame_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [bpr_pkg::SAMPLE_W-1:0] reduced_o,
  output logic                              last_of_frame_o
);
  import bpr_pkg::*;

  logic [CNT_W-1:0]      last_col_q, col_q, col_d, row_q, row_d;
  logic                  accept;
  tag_t                  tag_q, tag_d;
  logic [SAMPLE_W-1:0]   even_rd, odd_rd;
  logic                  push, busy;
  result_t               push_res, head;
  logic [OUTQ_CNT_W-1:0] q_count;
  logic [OUTQ_CNT_W:0]   pending;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_col_q <= last_column(LINE_WIDTH_RST);
    end else if (cfg_valid_i) begin
      last_col_q <= last_column(cfg_line_width_i);
    end
  end

  assign pending = (OUTQ_CNT_W + 1)'(q_count)
                 + (OUTQ_CNT_W + 1)'(tag_q.valid && tag_q.odd_row && tag_q.odd_col)
                 + (OUTQ_CNT_W + 1)'(busy);
  assign in_stall_o = (pending >= (OUTQ_CNT_W + 1)'(OUTQ_DEPTH));
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (end_of_frame_i) begin
        col_d = '0;
        row_d = '0;
      end else if (col_q >= last_col_q) begin
        col_d = '0;
        row_d = row_q + CNT_W'(1);
      end else begin
        col_d = col_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_comb begin
    tag_d.valid      = accept;
    tag_d.odd_row    = row_q[0];
    tag_d.odd_col    = col_q[0];
    tag_d.first_col  = (col_q == '0);
    tag_d.second_row = (row_q == CNT_W'(1));
    tag_d.eof        = end_of_frame_i;
    tag_d.sample     = sample_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_d;
    end
  end

  bpr_ram #(
    .Width (SAMPLE_W),
    .Depth (MAX_WIDTH)
  ) u_even_ram (
    .clk_i   (clk_i),
    .we_i    (accept && !row_q[0]),
    .waddr_i (col_q[ADDR_W-1:0]),
    .wdata_i (sample_i),
    .raddr_i (col_q[ADDR_W-1:0]),
    .rdata_o (even_rd)
  );

  bpr_ram #(
    .Width (SAMPLE_W),
    .Depth (MAX_WIDTH)
  ) u_odd_ram (
    .clk_i   (clk_i),
    .we_i    (accept && row_q[0]),
    .waddr_i (col_q[ADDR_W-1:0]),
    .wdata_i (sample_i),
    .raddr_i (col_q[ADDR_W-1:0]),
    .rdata_o (odd_rd)
  );

  bpr_filter u_filter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tag_i     (tag_q),
    .even_rd_i (even_rd),
    .odd_rd_i  (odd_rd),
    .push_o    (push),
    .result_o  (push_res),
    .busy_o    (busy)
  );

  bpr_outq u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .result_i (push_res),
    .pop_i    (!out_stall_i),
    .valid_o  (out_valid_o),
    .result_o (head),
    .count_o  (q_count)
  );

  assign reduced_o       = head.data;
  assign last_of_frame_o = head.last;

endmodule
